### rtl/lgen_pkg.sv
// Shared types, constants and helpers for the Life generations block.
`default_nettype none

package lgen_pkg;

  localparam int unsigned MAX_SIZE = 32;
  localparam int unsigned ROW_W    = 32;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned GEN_W    = 10;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned NCNT_W   = 4;
  localparam int unsigned OUT_DW   = 40;

  localparam logic [CNT_W-1:0] SIZE_MIN  = 6'd3;
  localparam logic [CNT_W-1:0] SIZE_MAX  = 6'd32;
  localparam logic [CNT_W-1:0] SIZE_RST  = 6'd5;
  localparam logic [GEN_W-1:0] GENS_RST  = 10'd1;

  // Neighbor counts of the B3/S23 rule
  localparam logic [NCNT_W-1:0] NB_SURVIVE = 4'd2;
  localparam logic [NCNT_W-1:0] NB_BIRTH   = 4'd3;

  // Configuration register indexes
  localparam logic CFG_GRID_SIZE   = 1'b0;
  localparam logic CFG_GENERATIONS = 1'b1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_GEN,
    ST_EMIT
  } state_e;

  // Tag that travels with a memory read during a generation sweep or emission
  typedef struct packed {
    logic             vld;
    logic             ok;
    logic [CNT_W-1:0] row;
  } rd_tag_t;

  // Control into the row unit: which center row the window holds
  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] row;
  } row_tag_t;

  // Clamp the configured size to the supported range
  function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] s);
    logic [CNT_W-1:0] r;
    r = s;
    if (s < SIZE_MIN) r = SIZE_MIN;
    if (s > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

  // Ones in the columns that are in use
  function automatic logic [ROW_W-1:0] row_mask(input logic [CNT_W-1:0] n);
    logic [ROW_W-1:0] m;
    if (n >= SIZE_MAX) m = '1;
    else m = (ROW_W'(1) << n[ADDR_W-1:0]) - ROW_W'(1);
    return m;
  endfunction

endpackage

`default_nettype wire

### rtl/lgen_lane.sv
// One cell lane: counts the eight Moore neighbors and applies the Life rule.
`default_nettype none

module lgen_lane
  import lgen_pkg::*;
(
  input  logic [2:0] above_i,  // columns j-1, j, j+1
  input  logic [2:0] here_i,
  input  logic [2:0] below_i,
  output logic       next_o
);

  logic [NCNT_W-1:0] cnt;

  // Sum the neighbors, the cell itself excluded
  assign cnt = NCNT_W'(above_i[0]) + NCNT_W'(above_i[1]) + NCNT_W'(above_i[2])
             + NCNT_W'(here_i[0])  + NCNT_W'(here_i[2])
             + NCNT_W'(below_i[0]) + NCNT_W'(below_i[1]) + NCNT_W'(below_i[2]);

  // Born with three, survive with two or three
  assign next_o = (cnt == NB_BIRTH) || (here_i[1] && (cnt == NB_SURVIVE));

endmodule

`default_nettype wire

### rtl/lgen_row.sv
// Row unit: one lane per column, merged into the registered next-generation row.
`default_nettype none

module lgen_row
  import lgen_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  row_tag_t         tag_i,
  input  logic [ROW_W-1:0] above_i,
  input  logic [ROW_W-1:0] here_i,
  input  logic [ROW_W-1:0] below_i,
  input  logic [ROW_W-1:0] mask_i,
  output row_tag_t         tag_o,
  output logic [ROW_W-1:0] cells_o
);

  logic [ROW_W+1:0] above_pad, here_pad, below_pad;
  logic [ROW_W-1:0] lanes;
  row_tag_t         tag_d, tag_q;
  logic [ROW_W-1:0] cells_d, cells_q;

  // Dead cells beyond both edges
  assign above_pad = {1'b0, above_i, 1'b0};
  assign here_pad  = {1'b0, here_i, 1'b0};
  assign below_pad = {1'b0, below_i, 1'b0};

  for (genvar j = 0; j < ROW_W; j++) begin : g_lane
    lgen_lane u_lane (
      .above_i (above_pad[j+2:j]),
      .here_i  (here_pad[j+2:j]),
      .below_i (below_pad[j+2:j]),
      .next_o  (lanes[j])
    );
  end

  // Merge lanes and drop columns outside the grid
  assign cells_d = lanes & mask_i;
  assign tag_d   = tag_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
  end

  assign tag_o   = tag_q;
  assign cells_o = cells_q;

endmodule

`default_nettype wire

### rtl/life_automaton_generations.sv
// Top level: grid memory, load/sweep/emit sequencer and row window.
//
//   channel   | dir | transfer moves
//   s_axis    | in  | one grid row, tlast on the final row
//   m_axis    | out | one final row with its index, tlast on the last row
//   cfg       | in  | register write, index 0 grid_size, 1 generations
//
// Loading takes one row per cycle into the single-port-write grid memory.
// Each generation sweeps rows 0..n through the memory read port and the
// 32-lane row unit. Emission passes each row through the registered memory
// read, then the output register, and issues no new read while one is in
// flight. Reset is asynchronous and needs no clearing pass: rows past the
// load count read as dead. Input is held off from the last row until the
// final row transfer; output stalls simply hold the sequencer.
`default_nettype none

module life_automaton_generations
  import lgen_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // cfg
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ROW_W-1:0]  s_axis_tdata,   // [31:0] row_cells
  input  logic              s_axis_tlast,   // row_last
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_DW-1:0] m_axis_tdata,   // [31:0] out_row_cells, [36:32] out_row_index
  output logic              m_axis_tlast    // out_last
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  size_q;
  logic [GEN_W-1:0]  gens_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [GEN_W-1:0]  gleft_q, gleft_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  eptr_q, eptr_d;
  rd_tag_t           tag_q, tag_d;
  rd_tag_t           etag_q, etag_d;
  logic              win_vld_q, win_vld_d;
  logic [CNT_W-1:0]  win_row_q, win_row_d;
  logic [ROW_W-1:0]  above_q, here_q, below_q;
  logic              out_vld_q, out_vld_d;
  logic [ROW_W-1:0]  out_cells_q;
  logic [ADDR_W-1:0] out_row_q;
  logic              out_last_q;

  logic [CNT_W-1:0]  n_eff;
  logic [ROW_W-1:0]  mask;
  logic              in_xfer, out_xfer;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [ROW_W-1:0]  wr_data, rdata_q;
  logic [ROW_W-1:0]  grid_mem [MAX_SIZE];
  logic              sweep_start, gen_done, emit_issue;
  row_tag_t          row_in, row_out;
  logic [ROW_W-1:0]  row_cells;
  logic [ADDR_W-1:0] last_row;

  assign n_eff    = eff_size(size_q);
  assign mask     = row_mask(n_eff);
  assign last_row = ADDR_W'(n_eff - CNT_W'(1));
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RST;
      gens_q <= GENS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_SIZE:   size_q <= cfg_data_i[CNT_W-1:0];
        CFG_GENERATIONS: gens_q <= cfg_data_i[GEN_W-1:0];
        default:         ;
      endcase
    end
  end

  // Row unit: center row is one behind the newest row in the window
  assign row_in.vld = win_vld_q && (win_row_q != '0);
  assign row_in.row = ADDR_W'(win_row_q - CNT_W'(1));

  lgen_row u_row (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (row_in),
    .above_i (above_q),
    .here_i  (here_q),
    .below_i (below_q),
    .mask_i  (mask),
    .tag_o   (row_out),
    .cells_o (row_cells)
  );

  assign gen_done = (state_q == ST_GEN) && row_out.vld && (row_out.row == last_row);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_xfer && s_axis_tlast) state_d = (gens_q == '0) ? ST_EMIT : ST_GEN;
      end
      ST_GEN: begin
        if (gen_done && (gleft_q == GEN_W'(1))) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xfer && m_axis_tlast) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Outputs of the sequencer: memory ports and sweep control
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    sweep_start   = 1'b0;
    emit_issue    = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        s_axis_tready = 1'b1;
        wr_en         = in_xfer && (cnt_q < n_eff);
        wr_addr       = cnt_q[ADDR_W-1:0];
        wr_data       = s_axis_tdata;
        sweep_start   = in_xfer && s_axis_tlast;
      end
      ST_GEN: begin
        rd_en       = (ptr_q <= n_eff);
        rd_addr     = ptr_q[ADDR_W-1:0];
        wr_en       = row_out.vld;
        wr_addr     = row_out.row;
        wr_data     = row_cells;
        sweep_start = gen_done;
      end
      ST_EMIT: begin
        emit_issue = (eptr_q < n_eff) && !etag_q.vld && (!out_vld_q || m_axis_tready);
        rd_en      = emit_issue;
        rd_addr    = eptr_q[ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  // Grid memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) grid_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= grid_mem[rd_addr];
  end

  // Load count, generation count, read pointers and tags
  always_comb begin
    cnt_d   = cnt_q;
    gleft_d = gleft_q;
    ptr_d   = ptr_q;
    eptr_d  = eptr_q;
    tag_d   = '0;
    etag_d  = etag_q;

    if (in_xfer) cnt_d = (cnt_q < n_eff) ? cnt_q + CNT_W'(1) : n_eff;
    if (in_xfer && s_axis_tlast) begin
      gleft_d = gens_q;
      eptr_d  = '0;
    end

    if ((state_q == ST_GEN) && rd_en) begin
      tag_d.vld = 1'b1;
      tag_d.ok  = (ptr_q < cnt_q);
      tag_d.row = ptr_q;
      ptr_d     = ptr_q + CNT_W'(1);
    end
    if (gen_done) begin
      gleft_d = gleft_q - GEN_W'(1);
      cnt_d   = n_eff;
    end
    if (sweep_start) ptr_d = '0;

    if (etag_q.vld) etag_d.vld = 1'b0;
    if (emit_issue) begin
      etag_d.vld = 1'b1;
      etag_d.ok  = (eptr_q < cnt_q);
      etag_d.row = eptr_q;
      eptr_d     = eptr_q + CNT_W'(1);
    end
    if (out_xfer && m_axis_tlast) cnt_d = '0;
  end

  // Window advances when read data arrives
  always_comb begin
    win_vld_d = tag_q.vld;
    win_row_d = tag_q.row;
  end

  always_ff @(posedge clk_i) begin
    if (sweep_start) begin
      above_q <= '0;
      here_q  <= '0;
      below_q <= '0;
    end else if (tag_q.vld) begin
      above_q <= here_q;
      here_q  <= below_q;
      below_q <= tag_q.ok ? (rdata_q & mask) : '0;
    end
  end

  // Output register loads from the emit read
  assign out_vld_d = etag_q.vld ? 1'b1 : (out_xfer ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i) begin
    if (etag_q.vld) begin
      out_cells_q <= etag_q.ok ? (rdata_q & mask) : '0;
      out_row_q   <= etag_q.row[ADDR_W-1:0];
      out_last_q  <= (etag_q.row[ADDR_W-1:0] == last_row);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      gleft_q   <= '0;
      ptr_q     <= '0;
      eptr_q    <= '0;
      tag_q     <= '0;
      etag_q    <= '0;
      win_vld_q <= 1'b0;
      win_row_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      gleft_q   <= gleft_d;
      ptr_q     <= ptr_d;
      eptr_q    <= eptr_d;
      tag_q     <= tag_d;
      etag_q    <= etag_d;
      win_vld_q <= win_vld_d;
      win_row_q <= win_row_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_row_q, out_cells_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

### rtl/lgen_chk.sv
// Port-level checker for the Life generations block, bound to the top level.
`default_nettype none

module lgen_chk
  import lgen_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic              s_axis_tlast,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [OUT_DW-1:0] m_axis_tdata,
  input  logic              m_axis_tlast
);

  // No row is taken while results are being shown
  a_no_load_during_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while output valid");

  // The final row closes the input until the grid is emitted
  a_close_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still ready after last row");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output changed under stall");

  // Padding bits of the result stay zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_DW-1:37] == '0))
    else $error("output padding not zero");

endmodule

bind life_automaton_generations lgen_chk u_lgen_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
